### rtl/positional_insert_list_top_assert.svh
`ifndef POSITIONAL_INSERT_LIST_TOP_ASSERT_SVH
`define POSITIONAL_INSERT_LIST_TOP_ASSERT_SVH

// check prop at every edge outside reset
`define PIL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check prop at every edge, reset included
`define PIL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pil_pkg.sv
package pil_pkg;

  localparam int CAPACITY_DEFAULT = 16;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_FRONT  = 2'd1;
  localparam logic [1:0] CMD_AT_POS = 2'd2;
  localparam logic [1:0] CMD_LIST   = 2'd3;

  localparam logic [2:0] KIND_INSERTED = 3'd0;
  localparam logic [2:0] KIND_FULL     = 3'd1;
  localparam logic [2:0] KIND_BADPOS   = 3'd2;
  localparam logic [2:0] KIND_EMPTY    = 3'd3;
  localparam logic [2:0] KIND_ELEMENT  = 3'd4;

  typedef struct packed {
    logic       load;
    logic       insert;
    logic       rotate;
    logic [2:0] kind;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic pos_zero;
    logic idx_last;
  } dp_sts_t;

endpackage

### rtl/positional_insert_list_top.sv
// A result is registered and appears in the cycle after its command is accepted.
// A listing gives one element a cycle while out_ready does not stall it, set by
// the rotation of the cell register through cell 0.
// Reset (synchronous, active high) empties the list and drops any pending result;
// cell contents are not cleared and are never read before being written.
`include "positional_insert_list_top_assert.svh"

module positional_insert_list_top #(
  parameter int CAPACITY = pil_pkg::CAPACITY_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] value,
  input  logic [7:0]         position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         kind,
  output logic signed [31:0] element,
  output logic [3:0]         slot,
  output logic [4:0]         count,
  output logic [4:0]         free_space,
  output logic               last
);

  pil_pkg::dp_cmd_t dcmd;
  pil_pkg::dp_sts_t sts;

  pil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .dcmd      (dcmd)
  );

  pil_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .dcmd       (dcmd),
    .sts        (sts),
    .cmd        (cmd),
    .value      (value),
    .position   (position),
    .kind       (kind),
    .element    (element),
    .slot       (slot),
    .count      (count),
    .free_space (free_space),
    .last       (last)
  );

  `PIL_ASSERT(a_insert_single, (in_valid && in_ready && cmd != pil_pkg::CMD_LIST) |=> (out_valid && last), "non-listing command must give one final result")
  `PIL_ASSERT(a_list_blocks, (out_valid && !last) |-> !in_ready, "command accepted during a listing")
  `PIL_ASSERT(a_full_no_space, (out_valid && kind == pil_pkg::KIND_FULL) |-> (free_space == '0), "full report with free space left")
  `PIL_ASSERT_ALWAYS(a_reset_drop, rst |=> !out_valid, "result pending after reset")

endmodule

### rtl/pil_dp.sv
module pil_dp #(
  parameter int CAPACITY = pil_pkg::CAPACITY_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  pil_pkg::dp_cmd_t    dcmd,
  output pil_pkg::dp_sts_t    sts,
  input  logic [1:0]          cmd,
  input  logic signed [31:0]  value,
  input  logic [7:0]          position,
  output logic [2:0]          kind,
  output logic signed [31:0]  element,
  output logic [3:0]          slot,
  output logic [4:0]          count,
  output logic [4:0]          free_space,
  output logic                last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int AW = ((CW > 8) ? CW : 8) + 1;

  logic [31:0]   cells [CAPACITY];
  logic [CW-1:0] stored;
  logic [IW-1:0] idx;

  logic [CW-1:0] last_ix;
  logic [AW-1:0] cnt_ext;
  logic [AW-1:0] pos_ext;
  logic [AW-1:0] at_w;
  logic [IW-1:0] at;
  logic [CW-1:0] cnt_after;
  logic [CW-1:0] free_after;
  logic [IW-1:0] slot_src;
  logic [IW+3:0] slot_pad;
  logic [CW+4:0] cnt_pad;
  logic [CW+4:0] free_pad;

  assign last_ix = stored - CW'(1);
  assign cnt_ext = AW'(stored);
  assign pos_ext = AW'(position);

  always_comb begin
    case (cmd)
      pil_pkg::CMD_APPEND: at_w = cnt_ext;
      pil_pkg::CMD_FRONT:  at_w = '0;
      default: begin
        if (pos_ext > cnt_ext + AW'(1)) begin
          at_w = cnt_ext;
        end else begin
          at_w = pos_ext - AW'(1);
        end
      end
    endcase
  end

  assign at = at_w[IW-1:0];

  assign sts.empty    = (stored == '0);
  assign sts.full     = (stored == CW'(CAPACITY));
  assign sts.pos_zero = (position == '0);
  assign sts.idx_last = (CW'(idx) == last_ix);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int NX = (g == CAPACITY - 1) ? 0 : g + 1;
    localparam int PV = (g == 0) ? 0 : g - 1;
    always_ff @(posedge clk) begin
      if (dcmd.insert) begin
        if (IW'(g) == at) begin
          cells[g] <= value;
        end else if (IW'(g) > at) begin
          cells[g] <= cells[PV];
        end
      end else if (dcmd.rotate) begin
        if (CW'(g) == last_ix) begin
          cells[g] <= cells[0];
        end else if (CW'(g) < last_ix) begin
          cells[g] <= cells[NX];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= '0;
      idx    <= '0;
    end else begin
      if (dcmd.insert) begin
        stored <= stored + CW'(1);
      end
      if (dcmd.rotate) begin
        idx <= sts.idx_last ? '0 : idx + IW'(1);
      end
    end
  end

  assign cnt_after  = dcmd.insert ? stored + CW'(1) : stored;
  assign free_after = CW'(CAPACITY) - cnt_after;
  assign slot_src   = (dcmd.kind == pil_pkg::KIND_ELEMENT)  ? idx :
                      (dcmd.kind == pil_pkg::KIND_INSERTED) ? at  : '0;
  assign slot_pad   = {4'b0, slot_src};
  assign cnt_pad    = {5'b0, cnt_after};
  assign free_pad   = {5'b0, free_after};

  always_ff @(posedge clk) begin
    if (dcmd.load) begin
      kind       <= dcmd.kind;
      element    <= (dcmd.kind == pil_pkg::KIND_ELEMENT) ? cells[0] : '0;
      slot       <= slot_pad[3:0];
      count      <= cnt_pad[4:0];
      free_space <= free_pad[4:0];
      last       <= dcmd.last;
    end
  end

endmodule

### rtl/pil_ctrl.sv
module pil_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       cmd,
  output logic             out_valid,
  input  logic             out_ready,
  input  pil_pkg::dp_sts_t sts,
  output pil_pkg::dp_cmd_t dcmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && adv;

  always_comb begin
    dcmd       = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          dcmd.load = 1'b1;
          dcmd.last = 1'b1;
          if (cmd == pil_pkg::CMD_LIST) begin
            if (sts.empty) begin
              dcmd.kind = pil_pkg::KIND_EMPTY;
            end else begin
              dcmd.kind   = pil_pkg::KIND_ELEMENT;
              dcmd.rotate = 1'b1;
              dcmd.last   = sts.idx_last;
              if (!sts.idx_last) begin
                state_next = ST_LIST;
              end
            end
          end else if (sts.full) begin
            dcmd.kind = pil_pkg::KIND_FULL;
          end else if (cmd == pil_pkg::CMD_AT_POS && sts.pos_zero) begin
            dcmd.kind = pil_pkg::KIND_BADPOS;
          end else begin
            dcmd.kind   = pil_pkg::KIND_INSERTED;
            dcmd.insert = 1'b1;
          end
        end
      end
      ST_LIST: begin
        if (adv) begin
          dcmd.load   = 1'b1;
          dcmd.kind   = pil_pkg::KIND_ELEMENT;
          dcmd.rotate = 1'b1;
          dcmd.last   = sts.idx_last;
          if (sts.idx_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid_next = dcmd.load || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
